>>> hdl/radix_integer_to_ascii_core_macros.svh
// Assertion macros for the radix integer-to-ASCII core.
// Included by the top level; depends on nothing else.
`ifndef RADIX_INTEGER_TO_ASCII_CORE_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RITA_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rita: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RITA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rita: next-cycle check failed");

`endif

>>> hdl/rita_pkg.sv
// Shared sizes, character codes, state type and control structs
// for the radix integer-to-ASCII core. Depends on nothing.
package rita_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int DIGIT_BUFFER = 32;
  localparam int MAX_FIELD    = 64;

  localparam int STEP_W = $clog2(VALUE_BITS);
  localparam int IDX_W  = $clog2(DIGIT_BUFFER);
  localparam int NDIG_W = $clog2(DIGIT_BUFFER + 1);
  localparam int REM_W  = 5;    // radix up to 16, shifted remainder below 32
  localparam int CNT_W  = 8;    // pads + sign + digits always below 256
  localparam int WID_W  = 7;
  localparam int CHAR_W = 7;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;

  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIZE,
    ST_EMIT
  } rita_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic size;
    logic emit;
  } rita_cmd_t;

  typedef struct packed {
    logic div_last;
    logic div_finish;
    logic total_zero;
    logic emit_last;
    logic slot_free;
  } rita_sts_t;

  function automatic logic [REM_W-1:0] radix_of(input logic [1:0] sel);
    logic [REM_W-1:0] r;
    unique case (sel)
      BASE_BIN: r = 5'd2;
      BASE_OCT: r = 5'd8;
      BASE_DEC: r = 5'd10;
      BASE_HEX: r = 5'd16;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

>>> hdl/rita_in_if.sv
// Input channel: one number plus its formatting options per word.
// Depends on rita_pkg for field widths.
interface rita_in_if;
  logic                           valid;
  logic                           ready;
  logic [rita_pkg::VALUE_BITS-1:0] value;
  logic [1:0]                     base_select;
  logic                           is_signed;
  logic [rita_pkg::WID_W-1:0]     min_width;
  logic                           zero_pad;
  logic [rita_pkg::WID_W-1:0]     room;

  modport source (output valid, value, base_select, is_signed, min_width, zero_pad, room,
                  input ready);
  modport sink   (input valid, value, base_select, is_signed, min_width, zero_pad, room,
                  output ready);
endinterface

>>> hdl/rita_out_if.sv
// Output channel: one ASCII character and its end-of-field flag per word.
// Depends on rita_pkg for field widths.
interface rita_out_if;
  logic                        valid;
  logic                        ready;
  logic [rita_pkg::CHAR_W-1:0] out_char;
  logic                        last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

>>> hdl/rita_ctrl.sv
// Sequencer for the converter: accept, divide digit by digit, size the
// field, emit characters. Depends on rita_pkg.
module rita_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rita_pkg::rita_sts_t sts_i,
  output rita_pkg::rita_cmd_t cmd_o
);

  rita_pkg::rita_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rita_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rita_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rita_pkg::ST_DIVIDE;
        end
      end
      rita_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last && sts_i.div_finish) begin
          state_d = rita_pkg::ST_SIZE;
        end
      end
      rita_pkg::ST_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = sts_i.total_zero ? rita_pkg::ST_IDLE : rita_pkg::ST_EMIT;
      end
      rita_pkg::ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = rita_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = rita_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hdl/rita_dpath.sv
// Datapath: bit-serial restoring divider, digit stack, field sizing and
// the output character register. Depends on rita_pkg.
module rita_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rita_pkg::rita_cmd_t              cmd_i,
  output rita_pkg::rita_sts_t              sts_o,
  input  logic [rita_pkg::VALUE_BITS-1:0]  value_i,
  input  logic [1:0]                       base_select_i,
  input  logic                             is_signed_i,
  input  logic [rita_pkg::WID_W-1:0]       min_width_i,
  input  logic                             zero_pad_i,
  input  logic [rita_pkg::WID_W-1:0]       room_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rita_pkg::CHAR_W-1:0]      out_char_o,
  output logic                             out_last_o
);

  localparam int VB = rita_pkg::VALUE_BITS;
  localparam int CW = rita_pkg::CNT_W;

  logic [VB-1:0]                  num_q;
  logic [rita_pkg::REM_W-1:0]     rem_q, radix_q;
  logic [rita_pkg::STEP_W-1:0]    step_q;
  logic [rita_pkg::NDIG_W-1:0]    ndig_q;
  logic [3:0]                     digits_q [rita_pkg::DIGIT_BUFFER];
  logic                           neg_q, zero_pad_q;
  logic [rita_pkg::WID_W-1:0]     width_q, room_q;
  logic [CW-1:0]                  pads_q, total_q, pos_q;
  logic                           out_valid_q;
  logic [rita_pkg::CHAR_W-1:0]    out_char_q;
  logic                           out_last_q;

  logic                           in_neg;
  logic [rita_pkg::REM_W-1:0]     rem_sh, rem_nx;
  logic                           rem_ge;
  logic [VB-1:0]                  q_nx;
  logic [CW-1:0]                  text_len, width_ext, pads_nx, raw_len, limit, total_nx;
  logic [CW-1:0]                  rd_full;
  logic [rita_pkg::IDX_W-1:0]     rd_idx;
  logic [rita_pkg::CHAR_W-1:0]    char_nx;
  logic                           slot_free;

  assign in_neg = is_signed_i & value_i[VB-1];

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem_q[rita_pkg::REM_W-2:0], num_q[VB-1]};
  assign rem_ge = (rem_sh >= radix_q);
  assign rem_nx = rem_ge ? (rem_sh - radix_q) : rem_sh;
  assign q_nx   = {num_q[VB-2:0], rem_ge};

  // Field sizing: pads fill the width left over by sign and digits.
  assign text_len  = CW'(ndig_q) + CW'(neg_q);
  assign width_ext = CW'(width_q);
  assign pads_nx   = (width_ext > text_len) ? (width_ext - text_len) : '0;
  assign raw_len   = pads_nx + text_len;
  assign limit     = (CW'(room_q) < CW'(rita_pkg::MAX_FIELD)) ? CW'(room_q)
                                                               : CW'(rita_pkg::MAX_FIELD);
  assign total_nx  = (raw_len < limit) ? raw_len : limit;

  // Digits were pushed least significant first; read them back from the top.
  assign rd_full = CW'(ndig_q) - CW'(1) - pos_q + pads_q + CW'(neg_q);
  assign rd_idx  = rd_full[rita_pkg::IDX_W-1:0];

  always_comb begin
    if (pos_q < pads_q) begin
      char_nx = zero_pad_q ? rita_pkg::CHAR_ZERO : rita_pkg::CHAR_SPACE;
    end else if (neg_q && (pos_q == pads_q)) begin
      char_nx = rita_pkg::CHAR_MINUS;
    end else begin
      char_nx = rita_pkg::digit_char(digits_q[rd_idx]);
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  assign sts_o.div_last   = (step_q == rita_pkg::STEP_W'(VB - 1));
  assign sts_o.div_finish = (q_nx == '0) ||
                            (ndig_q == rita_pkg::NDIG_W'(rita_pkg::DIGIT_BUFFER - 1));
  assign sts_o.total_zero = (total_nx == '0);
  assign sts_o.emit_last  = (pos_q == (total_q - CW'(1)));
  assign sts_o.slot_free  = slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q      <= in_neg ? (~value_i + VB'(1)) : value_i;
      neg_q      <= in_neg;
      radix_q    <= rita_pkg::radix_of(base_select_i);
      width_q    <= min_width_i;
      room_q     <= room_i;
      zero_pad_q <= zero_pad_i;
      rem_q      <= '0;
      step_q     <= '0;
      ndig_q     <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= q_nx;
      if (sts_o.div_last) begin
        // Digit complete: push the remainder, restart for the quotient.
        digits_q[ndig_q[rita_pkg::IDX_W-1:0]] <= rem_nx[3:0];
        ndig_q <= ndig_q + rita_pkg::NDIG_W'(1);
        rem_q  <= '0;
        step_q <= '0;
      end else begin
        rem_q  <= rem_nx;
        step_q <= step_q + rita_pkg::STEP_W'(1);
      end
    end
    if (cmd_i.size) begin
      pads_q  <= pads_nx;
      total_q <= total_nx;
      pos_q   <= '0;
    end
    if (cmd_i.emit) begin
      out_char_q <= char_nx;
      out_last_q <= sts_o.emit_last;
      pos_q      <= pos_q + CW'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

>>> hdl/radix_integer_to_ascii_core.sv
// Radix integer-to-ASCII core: top level joining sequencer and datapath.
// Depends on rita_pkg, rita_in_if, rita_out_if, rita_ctrl, rita_dpath.
//
// Use: each word on in_i carries a number, a base (2, 8, 10, 16), a signed
// flag, a minimum field width, a pad choice and the room left in the
// destination buffer. The core answers with the formatted field on out_o,
// one ASCII character per word, pad characters first, then '-', then the
// digits most significant first; last marks the final character. A field
// cut to zero characters by room produces no output word at all.
// Sequence: accept the word, divide out digits one at a time in the single
// shared restoring divider, size the field, then emit one character per cycle
// while out_o is ready. The next word is taken once the last character sits
// in the output register.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties
// the output register. When the receiver stalls, the current character holds
// in the output register and character generation pauses until it is taken.
`include "radix_integer_to_ascii_core_macros.svh"

module radix_integer_to_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rita_in_if.sink     in_i,
  rita_out_if.source  out_o
);

  rita_pkg::rita_cmd_t cmd;
  rita_pkg::rita_sts_t sts;
  logic                in_ready;

  // Sequencer: owns the input handshake and steps the datapath.
  rita_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath: divider, digit stack, sizing and the output word register.
  rita_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (in_i.value),
    .base_select_i (in_i.base_select),
    .is_signed_i   (in_i.is_signed),
    .min_width_i   (in_i.min_width),
    .zero_pad_i    (in_i.zero_pad),
    .room_i        (in_i.room),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_char_o    (out_o.out_char),
    .out_last_o    (out_o.last)
  );

  // A load starts the divider, so the input must close right after it.
  `RITA_ASSERT_NEXT(a_busy_after_load, clk_i, rst_ni, cmd.load, !in_i.ready)
  // Characters are only produced while no new word can be taken.
  `RITA_ASSERT_NOW(a_no_accept_in_emit, clk_i, rst_ni, cmd.emit, !in_i.ready)
  // Dividing and emitting never overlap.
  `RITA_ASSERT_NOW(a_div_emit_excl, clk_i, rst_ni, cmd.div_step, !cmd.emit)
  // Emitting the final character reopens the input next cycle.
  `RITA_ASSERT_NEXT(a_ready_after_last, clk_i, rst_ni, cmd.emit && sts.emit_last, in_i.ready)

endmodule
